// File: design/lfcc_pkg.sv
// Shared types, codes and the CRC-16/ARC byte update for the frame checker.
`timescale 1ns / 1ps

package lfcc_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned COUNT_W = 10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

    localparam logic [CFG_INDEX_W-1:0] CFG_PREHEADER_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREHEADER_BYTES = 1'd1;

    typedef enum logic [2:0] {
        STATUS_OK = 3'd0,
        STATUS_TOO_SHORT = 3'd1,
        STATUS_TRUNCATED = 3'd2,
        STATUS_PREHEADER_MISMATCH = 3'd3,
        STATUS_CHECKSUM_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic in_last;
    } lfcc_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic is_payload;
        logic frame_done;
        logic frame_ok;
        logic op_is_sign;
        logic [2:0] status;
    } lfcc_out_t;

    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: design/lfcc_frame_parser.sv
// Frame parser: tracks the field phase, pre-header compare, CRC and verdict.
`timescale 1ns / 1ps

module lfcc_frame_parser
    import lfcc_pkg::*;
#(
    parameter int unsigned MAX_PREHEADER_BYTES = 8,
    parameter int unsigned SIGN_LENGTH_THRESHOLD = 33
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  lfcc_in_t item,
    input  logic [3:0] preheader_length,
    input  logic [63:0] preheader_bytes,
    output lfcc_out_t result
);

    localparam logic [3:0] MAX_LEN = 4'(MAX_PREHEADER_BYTES);
    localparam logic [COUNT_W-1:0] SIGN_THRESH = COUNT_W'(SIGN_LENGTH_THRESHOLD);

    typedef enum logic [2:0] {
        PH_PRE_LEN,
        PH_PRE_DATA,
        PH_PAY_LEN,
        PH_PAY_DATA,
        PH_POST_LEN,
        PH_POST_DATA,
        PH_TRAIL
    } phase_t;

    phase_t phase_reg, phase_upd, phase_next;
    logic [7:0] left_reg, left_upd, left_next;
    logic [7:0] index_reg, index_upd, index_next;
    logic [COUNT_W-1:0] count_reg, count_upd, count_next;
    logic [15:0] crc_reg, crc_upd, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_upd, rx_crc_next;
    logic mismatch_reg, mismatch_upd, mismatch_next;

    logic [3:0] explen;
    logic [7:0] expected_byte;
    logic [7:0] b;
    logic payload;
    status_t status;

    assign b = item.in_byte;
    assign explen = (preheader_length > MAX_LEN) ? MAX_LEN : preheader_length;
    assign expected_byte = preheader_bytes[{index_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        phase_upd = phase_reg;
        left_upd = left_reg;
        index_upd = index_reg;
        crc_upd = crc_reg;
        rx_crc_upd = rx_crc_reg;
        mismatch_upd = mismatch_reg;
        payload = 1'b0;
        count_upd = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;

        unique case (phase_reg)
            PH_PRE_LEN:
            begin
                left_upd = b;
                index_upd = 8'd0;
                if (b < {4'd0, explen})
                begin
                    mismatch_upd = 1'b1;
                end
                phase_upd = (b != 8'd0) ? PH_PRE_DATA : PH_PAY_LEN;
            end
            PH_PRE_DATA:
            begin
                if (index_reg < {4'd0, explen} && b != expected_byte)
                begin
                    mismatch_upd = 1'b1;
                end
                crc_upd = crc16_arc_byte(crc_reg, b);
                index_upd = index_reg + 8'd1;
                left_upd = left_reg - 8'd1;
                if (left_upd == 8'd0)
                begin
                    phase_upd = PH_PAY_LEN;
                end
            end
            PH_PAY_LEN:
            begin
                left_upd = b;
                index_upd = 8'd0;
                phase_upd = (b != 8'd0) ? PH_PAY_DATA : PH_POST_LEN;
            end
            PH_PAY_DATA:
            begin
                payload = 1'b1;
                crc_upd = crc16_arc_byte(crc_reg, b);
                left_upd = left_reg - 8'd1;
                if (left_upd == 8'd0)
                begin
                    phase_upd = PH_POST_LEN;
                end
            end
            PH_POST_LEN:
            begin
                left_upd = b;
                index_upd = 8'd0;
                rx_crc_upd = 16'd0;
                phase_upd = (b != 8'd0) ? PH_POST_DATA : PH_TRAIL;
            end
            PH_POST_DATA:
            begin
                if (index_reg == 8'd0)
                begin
                    rx_crc_upd = {rx_crc_reg[15:8], b};
                end
                else if (index_reg == 8'd1)
                begin
                    rx_crc_upd = {b, rx_crc_reg[7:0]};
                end
                index_upd = index_reg + 8'd1;
                left_upd = left_reg - 8'd1;
                if (left_upd == 8'd0)
                begin
                    phase_upd = PH_TRAIL;
                end
            end
            PH_TRAIL:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (count_upd < SIGN_THRESH)
        begin
            status = STATUS_TOO_SHORT;
        end
        else if (phase_upd != PH_TRAIL || index_upd < 8'd2)
        begin
            status = STATUS_TRUNCATED;
        end
        else if (mismatch_upd)
        begin
            status = STATUS_PREHEADER_MISMATCH;
        end
        else if (rx_crc_upd != crc_upd)
        begin
            status = STATUS_CHECKSUM_MISMATCH;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        result.out_byte = b;
        result.is_payload = payload;
        result.frame_done = item.in_last;
        result.frame_ok = item.in_last && (status == STATUS_OK);
        result.op_is_sign = item.in_last && (count_upd > SIGN_THRESH);
        result.status = item.in_last ? status : STATUS_OK;
    end

    always_comb
    begin
        if (item.in_last)
        begin
            phase_next = PH_PRE_LEN;
            left_next = 8'd0;
            index_next = 8'd0;
            count_next = '0;
            crc_next = 16'd0;
            rx_crc_next = 16'd0;
            mismatch_next = 1'b0;
        end
        else
        begin
            phase_next = phase_upd;
            left_next = left_upd;
            index_next = index_upd;
            count_next = count_upd;
            crc_next = crc_upd;
            rx_crc_next = rx_crc_upd;
            mismatch_next = mismatch_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE_LEN;
            left_reg <= 8'd0;
            index_reg <= 8'd0;
            count_reg <= '0;
            crc_reg <= 16'd0;
            rx_crc_reg <= 16'd0;
            mismatch_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg <= left_next;
            index_reg <= index_next;
            count_reg <= count_next;
            crc_reg <= crc_next;
            rx_crc_reg <= rx_crc_next;
            mismatch_reg <= mismatch_next;
        end
    end

endmodule

// File: design/length_prefixed_frame_crc16_checker.sv
// Top level of the length-prefixed frame checker with CRC-16/ARC.
`timescale 1ns / 1ps

// Takes one frame byte per transfer and returns one result per byte via the
// input and result registers, at a rate of one byte per clock while out_stall
// is low. The input register feeds the frame parser, whose combinational CRC
// byte update and pre-header compare set the path into the result register.
// in_stall rises only when both the input and result registers hold data and
// out_stall is high. Configuration is taken on every cycle (cfg_ready is always
// high) and should be written only while no frame is in progress.
module length_prefixed_frame_crc16_checker
    import lfcc_pkg::*;
#(
    parameter int unsigned MAX_PREHEADER_BYTES = 8,
    parameter int unsigned SIGN_LENGTH_THRESHOLD = 33
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  lfcc_in_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output lfcc_out_t out_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    logic in_valid_reg;
    lfcc_in_t in_item_reg;
    logic out_valid_reg;
    lfcc_out_t out_item_reg;
    logic [3:0] preheader_length_reg;
    logic [63:0] preheader_bytes_reg;

    logic advance;
    logic accept;
    lfcc_out_t result;

    assign advance = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_item_reg;

    lfcc_frame_parser #(
        .MAX_PREHEADER_BYTES(MAX_PREHEADER_BYTES),
        .SIGN_LENGTH_THRESHOLD(SIGN_LENGTH_THRESHOLD)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .step(advance),
        .item(in_item_reg),
        .preheader_length(preheader_length_reg),
        .preheader_bytes(preheader_bytes_reg),
        .result(result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            preheader_length_reg <= 4'd0;
            preheader_bytes_reg <= 64'd0;
        end
        else
        begin
            in_valid_reg <= accept || (in_valid_reg && !advance);
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PREHEADER_LENGTH: preheader_length_reg <= cfg_data[3:0];
                    CFG_PREHEADER_BYTES: preheader_bytes_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule
